/* hw/rtl/backslash_escape_decoder_utf8_assert.svh */
// ----------------------------------------------------------------------------
// backslash escape decoder assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_UTF8_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_UTF8_ASSERT_SVH

// checked only outside reset
`define BEDU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BEDU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/bedu_pkg.sv */
// ----------------------------------------------------------------------------
// bedu_pkg
// shared types and constants of the backslash escape decoder
// ----------------------------------------------------------------------------
package bedu_pkg;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int RUN_W = 3;

   // one parsed item: an optional finished escape value, then up to two bytes
   typedef struct packed {
      logic             fin_raw;
      logic [RUN_W-1:0] fin_len;
      logic [31:0]      fin_val;
      logic [1:0]       tail_cnt;
      logic [7:0]       tail0;
      logic [7:0]       tail1;
      logic             tail_stop;
      logic [RUN_W-1:0] total;
   } cmd_type;

endpackage

/* hw/rtl/bedu_front.sv */
// ----------------------------------------------------------------------------
// bedu_front
// escape parser: takes one text byte per cycle while accept is high and queues what it yields
// ----------------------------------------------------------------------------
module bedu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             text_end,
   output logic             cmd_push,
   output bedu_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_OCT  = 3'd2,
      MODE_HEX  = 3'd3,
      MODE_UNI  = 3'd4,
      MODE_STOP = 3'd5
   } mode_type;

   localparam logic [7:0] CH_BSL  = 8'h5c;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_B    = 8'h62;
   localparam logic [7:0] CH_C    = 8'h63;
   localparam logic [7:0] CH_E_LO = 8'h65;
   localparam logic [7:0] CH_E_UP = 8'h45;
   localparam logic [7:0] CH_F    = 8'h66;
   localparam logic [7:0] CH_N    = 8'h6e;
   localparam logic [7:0] CH_R    = 8'h72;
   localparam logic [7:0] CH_T    = 8'h74;
   localparam logic [7:0] CH_V    = 8'h76;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_U_LO = 8'h75;
   localparam logic [7:0] CH_U_UP = 8'h55;

   localparam logic [7:0] BEL = 8'h07;
   localparam logic [7:0] BS  = 8'h08;
   localparam logic [7:0] ESC = 8'h1b;
   localparam logic [7:0] FF  = 8'h0c;
   localparam logic [7:0] LF  = 8'h0a;
   localparam logic [7:0] CR  = 8'h0d;
   localparam logic [7:0] TAB = 8'h09;
   localparam logic [7:0] VT  = 8'h0b;

   localparam logic [31:0] LIM1 = 32'h0000007f;
   localparam logic [31:0] LIM2 = 32'h000007ff;
   localparam logic [31:0] LIM3 = 32'h0000ffff;
   localparam logic [31:0] LIM4 = 32'h001fffff;
   localparam logic [31:0] LIM5 = 32'h03ffffff;
   localparam logic [31:0] LIM6 = 32'h7fffffff;

   localparam int RW = bedu_pkg::RUN_W;

   function automatic logic [RW-1:0] utf8_len(input logic [31:0] v);
      logic [RW-1:0] len;
      if (v <= LIM1) len = RW'(1);
      else if (v <= LIM2) len = RW'(2);
      else if (v <= LIM3) len = RW'(3);
      else if (v <= LIM4) len = RW'(4);
      else if (v <= LIM5) len = RW'(5);
      else if (v <= LIM6) len = RW'(6);
      else len = '0;
      return len;
   endfunction

   mode_type    mode_ff, mode_in;
   logic [3:0]  digits_ff, digits_in;
   logic [31:0] acc_ff, acc_in;

   logic        is_hex, is_oct, is_digit;
   logic [3:0]  hex_d;
   logic [31:0] acc_next;
   logic        fin_en;
   logic [31:0] fin_val;
   logic [RW-1:0] fin_len;
   logic [1:0]  tail_cnt;
   logic [7:0]  tail0, tail1;
   logic        tail_stop;

   always_comb begin
      is_hex = 1'b1;
      hex_d  = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         hex_d = 4'(in_byte - 8'h30);
      end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
         hex_d = 4'(in_byte - 8'h57);
      end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
         hex_d = 4'(in_byte - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
      is_oct   = (in_byte >= 8'h30) && (in_byte <= 8'h37);
      is_digit = (mode_ff == MODE_OCT) ? is_oct : is_hex;
      acc_next = ((mode_ff == MODE_OCT) ? {acc_ff[28:0], 3'b000} : {acc_ff[27:0], 4'b0000})
                 + {28'd0, hex_d};
   end

   always_comb begin
      mode_in   = mode_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      fin_en    = 1'b0;
      fin_val   = acc_ff;
      tail_cnt  = 2'd0;
      tail0     = in_byte;
      tail1     = in_byte;
      tail_stop = 1'b0;
      if (text_end) begin
         unique case (mode_ff)
            MODE_ESC: begin
               tail_cnt = 2'd1;
               tail0    = CH_BSL;
            end
            MODE_OCT, MODE_HEX, MODE_UNI: begin
               fin_en = 1'b1;
            end
            default: begin
            end
         endcase
         mode_in   = MODE_IDLE;
         digits_in = 4'd0;
         acc_in    = 32'd0;
      end else begin
         unique case (mode_ff)
            MODE_STOP: begin
            end
            MODE_ESC: begin
               mode_in   = MODE_IDLE;
               digits_in = 4'd0;
               acc_in    = 32'd0;
               tail_cnt  = 2'd1;
               unique case (in_byte) inside
                  CH_A:             tail0 = BEL;
                  CH_B:             tail0 = BS;
                  CH_E_LO, CH_E_UP: tail0 = ESC;
                  CH_F:             tail0 = FF;
                  CH_N:             tail0 = LF;
                  CH_R:             tail0 = CR;
                  CH_T:             tail0 = TAB;
                  CH_V:             tail0 = VT;
                  CH_BSL:           tail0 = CH_BSL;
                  CH_C: begin
                     tail0     = 8'h00;
                     tail_stop = 1'b1;
                     mode_in   = MODE_STOP;
                  end
                  CH_ZERO: begin
                     tail_cnt  = 2'd0;
                     mode_in   = MODE_OCT;
                     digits_in = 4'd3;
                  end
                  CH_X: begin
                     tail_cnt  = 2'd0;
                     mode_in   = MODE_HEX;
                     digits_in = 4'd2;
                  end
                  CH_U_LO: begin
                     tail_cnt  = 2'd0;
                     mode_in   = MODE_UNI;
                     digits_in = 4'd4;
                  end
                  CH_U_UP: begin
                     tail_cnt  = 2'd0;
                     mode_in   = MODE_UNI;
                     digits_in = 4'd8;
                  end
                  default: begin
                     tail_cnt = 2'd2;
                     tail0    = CH_BSL;
                     tail1    = in_byte;
                  end
               endcase
            end
            MODE_OCT, MODE_HEX, MODE_UNI: begin
               if (is_digit && digits_ff != 4'd0) begin
                  acc_in    = acc_next;
                  digits_in = digits_ff - 4'd1;
                  if (digits_ff == 4'd1) begin
                     fin_en    = 1'b1;
                     fin_val   = acc_next;
                     mode_in   = MODE_IDLE;
                     digits_in = 4'd0;
                     acc_in    = 32'd0;
                  end
               end else begin
                  fin_en    = 1'b1;
                  digits_in = 4'd0;
                  acc_in    = 32'd0;
                  if (in_byte == CH_BSL) begin
                     mode_in = MODE_ESC;
                  end else begin
                     mode_in  = MODE_IDLE;
                     tail_cnt = 2'd1;
                  end
               end
            end
            default: begin
               if (in_byte == CH_BSL) begin
                  mode_in = MODE_ESC;
               end else begin
                  mode_in  = MODE_IDLE;
                  tail_cnt = 2'd1;
               end
            end
         endcase
      end
   end

   // length of the finished escape value in output bytes
   always_comb begin
      fin_len = '0;
      if (fin_en) begin
         if (mode_ff == MODE_OCT) fin_len = RW'(fin_val[7:0] != 8'h00);
         else if (mode_ff == MODE_HEX) fin_len = RW'(1);
         else fin_len = utf8_len(fin_val);
      end
   end

   always_comb begin
      cmd.fin_raw   = (mode_ff != MODE_UNI);
      cmd.fin_len   = fin_len;
      cmd.fin_val   = fin_val;
      cmd.tail_cnt  = tail_cnt;
      cmd.tail0     = tail0;
      cmd.tail1     = tail1;
      cmd.tail_stop = tail_stop;
      cmd.total     = fin_len + RW'(tail_cnt);
      cmd_push      = accept && (cmd.total != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         digits_ff <= 4'd0;
         acc_ff    <= 32'd0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

/* hw/rtl/bedu_queue.sv */
// ----------------------------------------------------------------------------
// bedu_queue
// small command queue between the parser and the output sequencer
// ----------------------------------------------------------------------------
module bedu_queue #(
   parameter int DEPTH = bedu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  bedu_pkg::cmd_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output logic              rd_valid,
   output bedu_pkg::cmd_type rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bedu_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      rd_valid  = (count_ff != '0);
      rd_data   = entry_ff[rd_ptr_ff];
      do_wr     = wr_en && !full;
      do_rd     = rd_en && rd_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      // pointers wrap at the last entry
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in  = count_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hw/rtl/bedu_back.sv */
// ----------------------------------------------------------------------------
// bedu_back
// output sequencer: while pop keeps up, expands one command into its bytes, one per cycle
// ----------------------------------------------------------------------------
module bedu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  bedu_pkg::cmd_type q_data,
   output logic              q_pop,
   output logic              empty,
   input  logic              pop,
   output logic [7:0]        out_byte,
   output logic              stop_mark,
   output logic              run_last
);

   localparam int RW = bedu_pkg::RUN_W;

   localparam logic [7:0] LEAD2 = 8'hc0;
   localparam logic [7:0] LEAD3 = 8'he0;
   localparam logic [7:0] LEAD4 = 8'hf0;
   localparam logic [7:0] LEAD5 = 8'hf8;
   localparam logic [7:0] LEAD6 = 8'hfc;
   localparam logic [7:0] CONT  = 8'h80;

   function automatic logic [7:0] lead_prefix(input logic [RW-1:0] len);
      logic [7:0] p;
      unique case (len)
         RW'(2):  p = LEAD2;
         RW'(3):  p = LEAD3;
         RW'(4):  p = LEAD4;
         RW'(5):  p = LEAD5;
         RW'(6):  p = LEAD6;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // bits of v shifted right by six times n
   function automatic logic [7:0] chunk(input logic [31:0] v, input logic [RW-1:0] n);
      logic [7:0] c;
      unique case (n)
         RW'(0):  c = v[7:0];
         RW'(1):  c = v[13:6];
         RW'(2):  c = v[19:12];
         RW'(3):  c = v[25:18];
         RW'(4):  c = v[31:24];
         RW'(5):  c = {6'd0, v[31:30]};
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   bedu_pkg::cmd_type cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [RW-1:0]     idx_ff, idx_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_stop_ff, out_stop_in;
   logic              out_last_ff, out_last_in;

   logic              out_ready, emit, is_last, cur_done;
   logic [RW-1:0]     tail_idx, shift_n;
   logic [7:0]        fin_byte, tail_byte, sh_byte;

   always_comb begin
      out_ready = !out_valid_ff || pop;
      emit      = cur_valid_ff && out_ready;
      is_last   = (idx_ff == cur_ff.total - RW'(1));
      cur_done  = emit && is_last;
      q_pop     = q_valid && (!cur_valid_ff || cur_done);

      shift_n   = (idx_ff == '0) ? cur_ff.fin_len - RW'(1)
                                 : cur_ff.fin_len - RW'(1) - idx_ff;
      sh_byte   = chunk(cur_ff.fin_val, shift_n);
      if (cur_ff.fin_raw || cur_ff.fin_len == RW'(1)) begin
         fin_byte = cur_ff.fin_val[7:0];
      end else if (idx_ff == '0) begin
         fin_byte = lead_prefix(cur_ff.fin_len) | sh_byte;
      end else begin
         fin_byte = CONT | {2'b00, sh_byte[5:0]};
      end
      tail_idx  = idx_ff - cur_ff.fin_len;
      tail_byte = tail_idx[0] ? cur_ff.tail1 : cur_ff.tail0;

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + RW'(1);
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_stop_in  = out_stop_ff;
      out_last_in  = out_last_ff;
      if (out_ready) begin
         out_valid_in = emit;
         if (idx_ff < cur_ff.fin_len) begin
            out_byte_in = fin_byte;
            out_stop_in = 1'b0;
         end else begin
            out_byte_in = tail_byte;
            out_stop_in = cur_ff.tail_stop;
         end
         out_last_in = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_stop_ff <= out_stop_in;
      out_last_ff <= out_last_in;
   end

   assign empty     = !out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign stop_mark = out_stop_ff;
   assign run_last  = out_last_ff;

endmodule

/* hw/rtl/backslash_escape_decoder_utf8.sv */
// ----------------------------------------------------------------------------
// backslash_escape_decoder_utf8
// decodes backslash escapes in a byte stream, \u and \U as legacy utf-8
// ----------------------------------------------------------------------------
// The parser takes one text byte per cycle while full is low and queues a
// command for every byte that yields output; the sequencer then emits that
// command's bytes one per cycle while pop keeps up, so an item yields up to 7
// results (a six-byte utf-8 run plus a trailing byte) and the input keeps
// flowing until the QUEUE_DEPTH-entry command queue fills. A first result
// passes the queue entry, command register and output register before the
// result ports show it; items that yield nothing queue no command.
module backslash_escape_decoder_utf8 #(
   parameter int QUEUE_DEPTH = bedu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_text_end,
   input  logic       push,
   output logic       full,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_stop_mark,
   output logic       rsp_run_last,
   output logic       empty,
   input  logic       pop
);

   bedu_pkg::cmd_type wr_cmd, rd_cmd;
   logic              wr_push, rd_valid, rd_pop, accept;

   assign accept = push && !full;

   bedu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .text_end (req_text_end),
      .cmd_push (wr_push),
      .cmd      (wr_cmd)
   );

   bedu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_push),
      .wr_data  (wr_cmd),
      .full     (full),
      .rd_en    (rd_pop),
      .rd_valid (rd_valid),
      .rd_data  (rd_cmd)
   );

   bedu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (rd_valid),
      .q_data    (rd_cmd),
      .q_pop     (rd_pop),
      .empty     (empty),
      .pop       (pop),
      .out_byte  (rsp_out_byte),
      .stop_mark (rsp_stop_mark),
      .run_last  (rsp_run_last)
   );

endmodule

/* hw/rtl/bedu_checker.sv */
// ----------------------------------------------------------------------------
// bedu_checker
// port-level checks of the escape decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "backslash_escape_decoder_utf8_assert.svh"

module bedu_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_stop_mark,
   input logic       rsp_run_last,
   input logic       empty,
   input logic       pop
);

   `BEDU_ASSERT_ALWAYS(a_empty_after_reset, reset |=> empty, "results waiting after reset")
   `BEDU_ASSERT_ALWAYS(a_not_full_after_reset, reset |=> !full, "queue full after reset")
   `BEDU_ASSERT(a_result_held, !empty && !pop |=> !empty && $stable(rsp_out_byte), "result changed while stalled")
   `BEDU_ASSERT(a_stop_ends_run, !empty && rsp_stop_mark |-> rsp_run_last && rsp_out_byte == 8'h00, "stop mark not a lone zero result")

endmodule

bind backslash_escape_decoder_utf8 bedu_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .full          (full),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_stop_mark (rsp_stop_mark),
   .rsp_run_last  (rsp_run_last),
   .empty         (empty),
   .pop           (pop)
);
